// ===== hdl/ovl_pkg.sv =====
// Package for the octree voxel lookup: widths, codes and the child-slot helper.
// Used by octree_voxel_lookup and its port checker; depends on nothing.
`default_nettype none

package ovl_pkg;

    localparam int DEPTH_W        = 5;
    localparam int COORD_W        = 17;
    localparam int LINK_W         = 17;
    localparam int NODE_IDX_W     = 16;
    localparam int LEVEL_W        = 5;
    localparam int SLOT_W         = 3;

    localparam int DEF_MAX_DEPTH  = 16;
    localparam int DEF_NODE_COUNT = 65536;

    localparam logic [DEPTH_W-1:0] DEPTH_RESET = DEPTH_W'(16);
    localparam logic [LINK_W-1:0]  LINK_NONE   = {LINK_W{1'b1}};

    localparam logic OP_LOOKUP = 1'b0;
    localparam logic OP_WRITE  = 1'b1;

    typedef logic [LINK_W-1:0] link_t;

    // Form the child slot from bit sh of each coordinate (x bit 0, y bit 1, z bit 2)
    function automatic logic [SLOT_W-1:0] slot_of(
        input logic [NODE_IDX_W-1:0] x,
        input logic [NODE_IDX_W-1:0] y,
        input logic [NODE_IDX_W-1:0] z,
        input logic [DEPTH_W-1:0]    sh
    );
        logic [31:0] xs;
        logic [31:0] ys;
        logic [31:0] zs;
        xs = 32'(x) >> sh;
        ys = 32'(y) >> sh;
        zs = 32'(z) >> sh;
        return {zs[0], ys[0], xs[0]};
    endfunction

endpackage

`default_nettype wire

// ===== hdl/octree_voxel_lookup.sv =====
// Octree voxel lookup: child-link table memory, walk sequencer and depth register.
// Depends on ovl_pkg.
`default_nettype none

// A request is taken when start is high and busy is low. A write request
// (operation = 1) stores one child link in the same cycle and gives no result.
// A lookup with a coordinate outside 0..2^depth-1 answers -1 in the next cycle
// and leaves busy low. Any other lookup walks the tree from node 0 with one
// read of the link memory's read port per tree level: busy stays high until
// the walk reaches the target level, a missing child or a link past the
// table, and the result appears on voxel_index with result_valid high for
// one cycle as busy falls. The receiver cannot stall results; they must be
// taken in the cycle they appear. The link memory holds no reset value:
// lookups must only reach written links. The user must write the depth
// register through cfg_valid/cfg_ready/cfg_data only while the block is idle;
// the block itself does not enforce this, and cfg_ready is always high.
module octree_voxel_lookup
    import ovl_pkg::*;
#(
    parameter int MAX_DEPTH  = DEF_MAX_DEPTH,
    parameter int NODE_COUNT = DEF_NODE_COUNT
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    output      logic                         busy,
    input  wire logic                         operation,
    input  wire logic signed [COORD_W-1:0]    coord_x,
    input  wire logic signed [COORD_W-1:0]    coord_y,
    input  wire logic signed [COORD_W-1:0]    coord_z,
    input  wire logic        [LEVEL_W-1:0]    target_level,
    input  wire logic        [NODE_IDX_W-1:0] write_node,
    input  wire logic        [SLOT_W-1:0]     write_slot,
    input  wire logic signed [LINK_W-1:0]     write_link,
    output      logic                         result_valid,
    output      logic signed [LINK_W-1:0]     voxel_index,
    input  wire logic                         cfg_valid,
    output      logic                         cfg_ready,
    input  wire logic        [DEPTH_W-1:0]    cfg_data
);

    localparam int NODE_W   = (NODE_COUNT > 1) ? $clog2(NODE_COUNT) : 1;
    localparam int ADDR_W   = NODE_W + SLOT_W;
    localparam int MEM_SIZE = NODE_COUNT * 8;

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_WALK = 1'b1;

    // Configuration
    logic [DEPTH_W-1:0] depth_reg;
    logic [DEPTH_W-1:0] eff_depth;
    logic [DEPTH_W-1:0] eff_level;

    // Sequencer state
    logic                  state_reg, state_next;
    logic [NODE_IDX_W-1:0] x_reg, y_reg, z_reg;
    logic [NODE_IDX_W-1:0] x_next, y_next, z_next;
    logic [DEPTH_W-1:0]    sh_reg, sh_next;
    logic [DEPTH_W-1:0]    last_sh_reg, last_sh_next;
    logic [NODE_IDX_W-1:0] node_reg, node_next;
    logic                  valid_reg, valid_next;
    link_t                 index_reg, index_next;

    // Memory ports
    link_t              mem [MEM_SIZE];
    link_t              rd_data_reg;
    logic               rd_en;
    logic [ADDR_W-1:0]  rd_addr;
    logic               wr_en;
    logic [ADDR_W-1:0]  wr_addr;

    logic accept;
    logic outside;
    logic link_far;

    assign cfg_ready    = 1'b1;
    assign busy         = (state_reg == ST_WALK);
    assign accept       = start && !busy;
    assign result_valid = valid_reg;
    assign voxel_index  = index_reg;

    // Clamp depth to 1..MAX_DEPTH and level to 1..depth
    always_comb
    begin
        if (depth_reg == '0)
            eff_depth = DEPTH_W'(1);
        else if (32'(depth_reg) > MAX_DEPTH)
            eff_depth = DEPTH_W'(MAX_DEPTH);
        else
            eff_depth = depth_reg;

        if (target_level == '0)
            eff_level = DEPTH_W'(1);
        else if (DEPTH_W'(target_level) > eff_depth)
            eff_level = eff_depth;
        else
            eff_level = DEPTH_W'(target_level);
    end

    // A coordinate is outside when negative or at or above 2^depth
    assign outside = coord_x[COORD_W-1] || coord_y[COORD_W-1] || coord_z[COORD_W-1]
        || ((coord_x[NODE_IDX_W-1:0] >> eff_depth) != '0)
        || ((coord_y[NODE_IDX_W-1:0] >> eff_depth) != '0)
        || ((coord_z[NODE_IDX_W-1:0] >> eff_depth) != '0);

    // A link past the table ends the walk at that node
    assign link_far = (32'(rd_data_reg[NODE_IDX_W-1:0]) >= NODE_COUNT);

    // Write requests go straight into the table
    assign wr_en   = accept && (operation == OP_WRITE) && (32'(write_node) < NODE_COUNT);
    assign wr_addr = ADDR_W'({32'(write_node), write_slot});

    // Walk sequencer: issue one read per level, decide on the returned link
    always_comb
    begin
        state_next   = state_reg;
        x_next       = x_reg;
        y_next       = y_reg;
        z_next       = z_reg;
        sh_next      = sh_reg;
        last_sh_next = last_sh_reg;
        node_next    = node_reg;
        valid_next   = 1'b0;
        index_next   = index_reg;
        rd_en        = 1'b0;
        rd_addr      = '0;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && (operation == OP_LOOKUP))
                begin
                    if (outside)
                    begin
                        valid_next = 1'b1;
                        index_next = LINK_NONE;
                    end
                    else
                    begin
                        x_next       = coord_x[NODE_IDX_W-1:0];
                        y_next       = coord_y[NODE_IDX_W-1:0];
                        z_next       = coord_z[NODE_IDX_W-1:0];
                        sh_next      = eff_depth - DEPTH_W'(1);
                        last_sh_next = eff_level - DEPTH_W'(1);
                        node_next    = '0;
                        rd_en        = 1'b1;
                        rd_addr      = ADDR_W'(slot_of(coord_x[NODE_IDX_W-1:0],
                                                       coord_y[NODE_IDX_W-1:0],
                                                       coord_z[NODE_IDX_W-1:0],
                                                       eff_depth - DEPTH_W'(1)));
                        state_next   = ST_WALK;
                    end
                end
            end
            ST_WALK:
            begin
                priority if (rd_data_reg[LINK_W-1])
                begin
                    // Missing child: stop at the current node
                    valid_next = 1'b1;
                    index_next = LINK_W'(node_reg);
                    state_next = ST_IDLE;
                end
                else if ((sh_reg == last_sh_reg) || link_far)
                begin
                    // Last level reached, or nothing more can be read
                    valid_next = 1'b1;
                    index_next = rd_data_reg;
                    state_next = ST_IDLE;
                end
                else
                begin
                    // Advance one level down
                    node_next = rd_data_reg[NODE_IDX_W-1:0];
                    sh_next   = sh_reg - DEPTH_W'(1);
                    rd_en     = 1'b1;
                    rd_addr   = ADDR_W'({32'(rd_data_reg[NODE_IDX_W-1:0]),
                                         slot_of(x_reg, y_reg, z_reg,
                                                 sh_reg - DEPTH_W'(1))});
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            depth_reg <= DEPTH_RESET;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            if (cfg_valid && cfg_ready)
                depth_reg <= cfg_data;
        end
    end

    // Walk payload registers
    always_ff @(posedge clk)
    begin
        x_reg       <= x_next;
        y_reg       <= y_next;
        z_reg       <= z_next;
        sh_reg      <= sh_next;
        last_sh_reg <= last_sh_next;
        node_reg    <= node_next;
        index_reg   <= index_next;
    end

    // Child-link table: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= write_link;
        if (rd_en)
            rd_data_reg <= mem[rd_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/ovl_checker.sv =====
// Port-level checker for octree_voxel_lookup, attached by bind.
// Depends on ovl_pkg and the top-level port names.
`default_nettype none

module ovl_checker
    import ovl_pkg::*;
(
    input wire logic                      clk,
    input wire logic                      rst_n,
    input wire logic                      start,
    input wire logic                      busy,
    input wire logic                      operation,
    input wire logic signed [COORD_W-1:0] coord_x,
    input wire logic                      result_valid,
    input wire logic signed [LINK_W-1:0]  voxel_index
);

    // Drop no result: a write request never produces one
    a_write_silent: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_WRITE)) |=> !result_valid)
        else $error("result after a write request");

    // A negative x answers -1 in the next cycle
    a_outside: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_LOOKUP) && coord_x[COORD_W-1])
        |=> (result_valid && (voxel_index == LINK_NONE)))
        else $error("outside lookup did not answer -1");

    // A lookup either starts a walk or answers at once
    a_lookup_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == OP_LOOKUP)) |=> (busy || result_valid))
        else $error("lookup request lost");

    // Results only appear once the walk is over
    a_idle_result: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> !busy)
        else $error("result while busy");

    // Every finished walk delivers a result
    a_walk_result: assert property (@(posedge clk) disable iff (!rst_n)
        $fell(busy) |-> result_valid)
        else $error("walk ended without result");

endmodule

bind octree_voxel_lookup ovl_checker u_ovl_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .operation    (operation),
    .coord_x      (coord_x),
    .result_valid (result_valid),
    .voxel_index  (voxel_index)
);

`default_nettype wire

// ===== bench/testbench.sv =====
// Testbench for octree_voxel_lookup: builds child-link trees on demand, then
// checks each lookup answer against a local walk of the same tree.
// Depends on ovl_pkg and on the octree_voxel_lookup RTL.

package octree_check_pkg;
    import ovl_pkg::*;

    localparam int LINK_SLOTS = DEF_NODE_COUNT * 8;

    typedef struct {
        logic                      op;
        logic signed [COORD_W-1:0] x;
        logic signed [COORD_W-1:0] y;
        logic signed [COORD_W-1:0] z;
        logic [LEVEL_W-1:0]        level;
        logic [NODE_IDX_W-1:0]     node;
        logic [SLOT_W-1:0]         slot;
        link_t                     link;
    } octree_req_t;

    // Mirror of the child-link table and depth register, plus answers still due
    class voxel_tracker;
        link_t              link_table [LINK_SLOTS];
        bit                 link_known [LINK_SLOTS];
        logic [DEPTH_W-1:0] depth_reg;
        link_t              voxel_due [$];
        int                 errors;

        function new();
            depth_reg = DEPTH_RESET;
            errors    = 0;
        endfunction

        function void set_depth(logic [DEPTH_W-1:0] value);
            depth_reg = value;
        endfunction

        // Clamp the depth register to the range the walk supports
        function int span_bits();
            int d;
            d = int'(depth_reg);
            if (d < 1) d = 1;
            if (d > DEF_MAX_DEPTH) d = DEF_MAX_DEPTH;
            return d;
        endfunction

        function int pending();
            return voxel_due.size();
        endfunction

        // Walk from the root; report the first unwritten entry the walk would read
        function link_t walk_tree(octree_req_t r, output int missing);
            int    d;
            int    x;
            int    y;
            int    z;
            int    lvl;
            int    sh;
            int    slot;
            int    entry;
            int    node;
            link_t nxt;
            missing = -1;
            d   = span_bits();
            x   = int'(r.x);
            y   = int'(r.y);
            z   = int'(r.z);
            lvl = int'(r.level);
            if (x < 0 || y < 0 || z < 0 || x >= (1 << d) || y >= (1 << d) || z >= (1 << d))
                return LINK_NONE;
            if (lvl < 1) lvl = 1;
            if (lvl > d) lvl = d;
            node = 0;
            for (int s = 0; s < d - lvl + 1; s++)
            begin
                sh   = d - 1 - s;
                slot = ((x >> sh) & 1) | (((y >> sh) & 1) << 1) | (((z >> sh) & 1) << 2);
                if (node >= DEF_NODE_COUNT) break;
                entry = node * 8 + slot;
                if (!link_known[entry])
                begin
                    missing = entry;
                    break;
                end
                nxt = link_table[entry];
                // Negative link: no child, stop at the current node
                if (nxt[LINK_W-1]) break;
                node = int'(nxt);
            end
            return link_t'(node);
        endfunction

        // Apply an accepted request: store a link or queue the lookup answer
        function void note_request(octree_req_t r);
            int    missing;
            int    entry;
            link_t answer;
            if (r.op == OP_WRITE)
            begin
                if (int'(r.node) < DEF_NODE_COUNT)
                begin
                    entry = int'(r.node) * 8 + int'(r.slot);
                    link_table[entry] = r.link;
                    link_known[entry] = 1'b1;
                end
            end
            else
            begin
                answer    = walk_tree(r, missing);
                voxel_due = {voxel_due, answer};
            end
        endfunction

        // Compare one strobed answer with the oldest one due
        function void check_voxel(link_t got);
            link_t want;
            if (voxel_due.size() == 0)
            begin
                $display("%0t: voxel_index expected none, got %0d", $time, $signed(got));
                errors++;
            end
            else
            begin
                want = voxel_due.pop_front();
                if (got !== want)
                begin
                    $display("%0t: voxel_index expected %0d, got %0d",
                             $time, $signed(want), $signed(got));
                    errors++;
                end
            end
        endfunction
    endclass

endpackage

module testbench;
    import ovl_pkg::*;
    import octree_check_pkg::*;

    localparam int STALL_LIMIT   = 1000;
    localparam int SETTLE_CYCLES = DEF_MAX_DEPTH + 4;
    localparam int RANDOM_ITEMS  = 1500;
    localparam int PHASES        = 6;

    logic                         clk          = 1'b0;
    logic                         rst_n        = 1'b0;
    logic                         start        = 1'b0;
    logic                         busy;
    logic                         operation    = OP_LOOKUP;
    logic signed [COORD_W-1:0]    coord_x      = '0;
    logic signed [COORD_W-1:0]    coord_y      = '0;
    logic signed [COORD_W-1:0]    coord_z      = '0;
    logic        [LEVEL_W-1:0]    target_level = '0;
    logic        [NODE_IDX_W-1:0] write_node   = '0;
    logic        [SLOT_W-1:0]     write_slot   = '0;
    logic signed [LINK_W-1:0]     write_link   = '0;
    logic                         result_valid;
    logic signed [LINK_W-1:0]     voxel_index;
    logic                         cfg_valid    = 1'b0;
    logic                         cfg_ready;
    logic        [DEPTH_W-1:0]    cfg_data     = '0;

    voxel_tracker book;
    int           sent_items = 0;
    bit           no_gaps    = 1'b0;

    octree_voxel_lookup DUT (
        .clk          (clk),
        .rst_n        (rst_n),
        .start        (start),
        .busy         (busy),
        .operation    (operation),
        .coord_x      (coord_x),
        .coord_y      (coord_y),
        .coord_z      (coord_z),
        .target_level (target_level),
        .write_node   (write_node),
        .write_slot   (write_slot),
        .write_link   (write_link),
        .result_valid (result_valid),
        .voxel_index  (voxel_index),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data)
    );

    always #5 clk = ~clk;

    // Check every strobed answer at the edge that ends its cycle
    always @(posedge clk)
    begin
        if (rst_n && result_valid)
            book.check_voxel(voxel_index);
    end

    // End the run when nothing moves for too long
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((start && !busy) || result_valid || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("octree_voxel_lookup verification failed");
        $finish;
    end

    // Drive one request and hold it until the block takes it
    task automatic send_request(input octree_req_t r);
        operation    <= r.op;
        coord_x      <= r.x;
        coord_y      <= r.y;
        coord_z      <= r.z;
        target_level <= r.level;
        write_node   <= r.node;
        write_slot   <= r.slot;
        write_link   <= r.link;
        start        <= 1'b1;
        do @(posedge clk); while (busy);
        book.note_request(r);
        sent_items++;
        @(negedge clk);
    endtask

    // Drop start for a random gap now and then
    task automatic maybe_gap();
        if (!no_gaps && $urandom_range(0, 99) < 10)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 20)) @(negedge clk);
        end
    endtask

    // Hold off new requests until every lookup has answered
    task automatic drain_lookups();
        start <= 1'b0;
        do @(negedge clk); while (book.pending() != 0);
    endtask

    // Write the depth register once the block has settled
    task automatic write_depth(input logic [DEPTH_W-1:0] value);
        drain_lookups();
        repeat (SETTLE_CYCLES) @(negedge clk);
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        do @(posedge clk); while (!cfg_ready);
        book.set_depth(value);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Often small node numbers so that walks revisit nodes; some negative links
    function automatic link_t pick_link();
        case ($urandom_range(0, 9))
            0, 1:       return link_t'(32'd0 - $urandom_range(1, 65536));
            2, 3, 4, 5: return link_t'($urandom_range(0, 31));
            default:    return link_t'($urandom_range(0, 65535));
        endcase
    endfunction

    function automatic octree_req_t any_request(input logic op);
        octree_req_t r;
        r.op    = op;
        r.x     = COORD_W'($urandom);
        r.y     = COORD_W'($urandom);
        r.z     = COORD_W'($urandom);
        r.level = LEVEL_W'($urandom);
        r.node  = NODE_IDX_W'($urandom);
        r.slot  = SLOT_W'($urandom);
        r.link  = pick_link();
        return r;
    endfunction

    // Lookup with all coordinates inside the tree
    function automatic octree_req_t tree_lookup(input int span);
        octree_req_t r;
        int          top;
        r   = any_request(OP_LOOKUP);
        top = (1 << span) - 1;
        r.x = COORD_W'($urandom_range(0, top));
        r.y = COORD_W'($urandom_range(0, top));
        r.z = COORD_W'($urandom_range(0, top));
        if ($urandom_range(0, 9) < 7)
            r.level = LEVEL_W'($urandom_range(0, DEF_MAX_DEPTH));
        return r;
    endfunction

    // Lookup with one coordinate pushed outside the tree
    function automatic octree_req_t stray_lookup(input int span);
        octree_req_t               r;
        logic signed [COORD_W-1:0] wild;
        r = tree_lookup(span);
        if (span == DEF_MAX_DEPTH || $urandom_range(0, 1) == 0)
            wild = COORD_W'(32'd0 - $urandom_range(1, 65536));
        else
            wild = COORD_W'($urandom_range(1 << span, 65535));
        case ($urandom_range(0, 2))
            0:       r.x = wild;
            1:       r.y = wild;
            default: r.z = wild;
        endcase
        return r;
    endfunction

    // Load every link the walk will read, then send the lookup
    task automatic send_lookup(input octree_req_t r);
        octree_req_t w;
        int          missing;
        forever
        begin
            void'(book.walk_tree(r, missing));
            if (missing < 0) break;
            w      = any_request(OP_WRITE);
            w.node = NODE_IDX_W'(missing >> 3);
            w.slot = SLOT_W'(missing);
            maybe_gap();
            send_request(w);
        end
        maybe_gap();
        send_request(r);
    endtask

    task automatic send_link(input int node, input int slot, input int link);
        octree_req_t w;
        w      = any_request(OP_WRITE);
        w.node = NODE_IDX_W'(node);
        w.slot = SLOT_W'(slot);
        w.link = link_t'(link);
        send_request(w);
    endtask

    task automatic probe(input int x, input int y, input int z, input int level);
        octree_req_t r;
        r       = any_request(OP_LOOKUP);
        r.x     = COORD_W'(x);
        r.y     = COORD_W'(y);
        r.z     = COORD_W'(z);
        r.level = LEVEL_W'(level);
        send_lookup(r);
    endtask

    initial
    begin
        int stop_at;
        int pick;
        book = new();
        repeat (4) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Reset depth: root with no child, clamped levels
        send_link(0, 0, -1);
        probe(0, 0, 0, 0);
        // Each coordinate below the tree, and the most negative one
        probe(-1, 5, 5, 3);
        probe(5, -65536, 5, 3);
        probe(5, 5, -1, 3);
        probe(-65536, 65535, 65535, 16);
        // Largest node and link, then the most negative link
        send_link(0, 7, 65535);
        probe(65535, 65535, 65535, 16);
        probe(65535, 65535, 65535, 31);
        send_link(65535, 7, -65536);
        probe(65535, 65535, 65535, 15);
        probe(65535, 65535, 65535, 0);
        probe(0, 65535, 0, 16);
        // Depth of zero acts as one level
        write_depth('0);
        probe(1, 1, 1, 0);
        probe(2, 0, 0, 1);
        probe(1, 0, 1, 1);
        // Depth above the maximum acts as the maximum
        write_depth('1);
        probe(65535, 0, 0, 16);
        probe(0, 0, 65535, 2);

        for (int phase = 0; phase < PHASES; phase++)
        begin
            case (phase)
                0:       write_depth(DEPTH_W'($urandom_range(2, 6)));
                1:       write_depth(DEPTH_W'(DEF_MAX_DEPTH));
                2:       write_depth(DEPTH_W'(1));
                3:       write_depth(DEPTH_W'($urandom_range(0, 31)));
                4:       write_depth('1);
                default: write_depth(DEPTH_W'($urandom_range(7, 12)));
            endcase
            no_gaps = (phase == 1);
            stop_at = sent_items + RANDOM_ITEMS / PHASES;
            while (sent_items < stop_at)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 70)
                    send_lookup(tree_lookup(book.span_bits()));
                else if (pick < 82)
                    send_lookup(stray_lookup(book.span_bits()));
                else if (pick < 98)
                begin
                    maybe_gap();
                    send_request(any_request(OP_WRITE));
                end
                else
                    drain_lookups();
            end
        end

        drain_lookups();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (book.errors == 0 && book.pending() == 0)
            $display("octree_voxel_lookup verification clean");
        else
            $display("octree_voxel_lookup verification failed");
        $finish;
    end

endmodule
